[design/regula_falsi_cubic_root_top_macros.svh]
// Assertion macros shared by the regula falsi root finder RTL.
// Used by files that carry concurrent checks; needs clk and rst_n in scope.
`ifndef REGULA_FALSI_CUBIC_ROOT_TOP_MACROS_SVH
`define REGULA_FALSI_CUBIC_ROOT_TOP_MACROS_SVH

// antecedent implies consequent in the same cycle
`define RFCR_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// antecedent implies consequent in the next cycle
`define RFCR_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

[design/rfcr_pkg.sv]
// Package for the regula falsi cubic root finder: widths, codes, command types.
// No dependencies; used by every other RTL file except the assertion macro header.
`default_nettype none
package rfcr_pkg;

  localparam int IN_W       = 30;
  localparam int TOL_W      = 25;
  localparam int RES_W      = 39;
  localparam int ST_W       = 2;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 25;
  localparam int F_W        = 64;
  localparam int MUL_A_W    = 64;
  localparam int MUL_B_W    = 32;
  localparam int PROD_W     = MUL_A_W + MUL_B_W;
  localparam int Q_W        = 32;

  localparam int FRAC_BITS_DEF     = 24;
  localparam int MAX_ITER_BITS_DEF = 8;

  localparam logic [TOL_W-1:0] WTOL_RST  = 25'd168;
  localparam logic [TOL_W-1:0] RTOL_RST  = 25'd168;
  localparam int               LIMIT_RST = 100;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_WTOL  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_RTOL  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_LIMIT = 2'd2;

  typedef enum logic [ST_W-1:0] {
    ST_CONV    = 2'd0,
    ST_INVALID = 2'd1,
    ST_LIMIT   = 2'd2
  } status_t;

  typedef enum logic [1:0] {MS_SQ, MS_CUBE, MS_SEC} mul_src_t;
  typedef enum logic [1:0] {EV_A, EV_B, EV_X} ev_sel_t;
  typedef enum logic [1:0] {FD_A, FD_B, FD_X} f_dst_t;

  // controller -> datapath
  typedef struct packed {
    logic     load;
    logic     ev_load;
    ev_sel_t  ev_sel;
    logic     mul_start;
    mul_src_t mul_src;
    logic     cube_cap;
    logic     f_cap;
    f_dst_t   f_dst;
    logic     div_start;
    logic     x_cap;
    logic     it_clr;
    logic     it_inc;
    logic     update;
    logic     res_cap;
    status_t  res_st;
  } dp_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic mul_busy;
    logic div_busy;
    logic bad_bracket;
    logic stop_hit;
    logic it_last;
  } dp_sts_t;

  // clamp a wide function value to the residual range
  function automatic logic signed [RES_W-1:0] sat_res(input logic signed [F_W-1:0] v);
    logic signed [F_W-1:0] hi;
    logic signed [F_W-1:0] lo;
    hi = (F_W'(1) <<< (RES_W - 1)) - F_W'(1);
    lo = -(F_W'(1) <<< (RES_W - 1));
    if (v > hi) begin
      return hi[RES_W-1:0];
    end else if (v < lo) begin
      return lo[RES_W-1:0];
    end
    return v[RES_W-1:0];
  endfunction

endpackage
`default_nettype wire

[design/rfcr_if.sv]
// Valid/ready channel interfaces for bracket input and root result.
// Depends on rfcr_pkg.
`default_nettype none
interface rfcr_in_if;
  logic                                  valid;
  logic                                  ready;
  logic signed [rfcr_pkg::IN_W-1:0]      lower_bound;
  logic signed [rfcr_pkg::IN_W-1:0]      upper_bound;
  modport source (output valid, output lower_bound, output upper_bound, input ready);
  modport sink   (input valid, input lower_bound, input upper_bound, output ready);
endinterface

interface rfcr_out_if #(parameter int ITER_W = rfcr_pkg::MAX_ITER_BITS_DEF);
  logic                                  valid;
  logic                                  ready;
  logic signed [rfcr_pkg::IN_W-1:0]      root;
  logic signed [rfcr_pkg::RES_W-1:0]     residual;
  logic [rfcr_pkg::ST_W-1:0]             status;
  logic [ITER_W-1:0]                     iterations;
  modport source (output valid, output root, output residual, output status,
                  output iterations, input ready);
  modport sink   (input valid, input root, input residual, input status,
                  input iterations, output ready);
endinterface
`default_nettype wire

[design/rfcr_mul.sv]
// Bit-serial shift-add multiplier, 64 x 32 bits, one multiplier bit per cycle.
// Depends on rfcr_pkg.
`default_nettype none
module rfcr_mul (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           start,
  input  wire logic [rfcr_pkg::MUL_A_W-1:0]   op_a,
  input  wire logic [rfcr_pkg::MUL_B_W-1:0]   op_b,
  output logic                                busy,
  output logic [rfcr_pkg::PROD_W-1:0]         prod
);
  localparam int CntW = $clog2(rfcr_pkg::MUL_B_W + 1);

  logic [CntW-1:0]                 cnt_r;
  logic [rfcr_pkg::MUL_A_W-1:0]    a_r;
  logic [rfcr_pkg::MUL_B_W-1:0]    b_r;
  logic [rfcr_pkg::PROD_W-1:0]     acc_r;
  logic [rfcr_pkg::PROD_W-1:0]     acc_nxt;

  // MSB-first accumulate
  always_comb begin
    acc_nxt = acc_r << 1;
    if (b_r[rfcr_pkg::MUL_B_W-1]) begin
      acc_nxt = acc_nxt + rfcr_pkg::PROD_W'(a_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (start) begin
      cnt_r <= CntW'(rfcr_pkg::MUL_B_W);
    end else if (cnt_r != '0) begin
      cnt_r <= cnt_r - CntW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      a_r   <= op_a;
      b_r   <= op_b;
      acc_r <= '0;
    end else if (cnt_r != '0) begin
      b_r   <= b_r << 1;
      acc_r <= acc_nxt;
    end
  end

  assign busy = (cnt_r != '0);
  assign prod = acc_r;
endmodule
`default_nettype wire

[design/rfcr_div.sv]
// Restoring divider, one quotient bit per cycle; quotient known to fit 32 bits.
// Depends on rfcr_pkg.
`default_nettype none
module rfcr_div (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           start,
  input  wire logic [rfcr_pkg::PROD_W-1:0]    num,
  input  wire logic [rfcr_pkg::F_W-1:0]       den,
  output logic                                busy,
  output logic [rfcr_pkg::Q_W-1:0]            quo
);
  localparam int CntW = $clog2(rfcr_pkg::Q_W + 1);
  localparam int RemW = rfcr_pkg::PROD_W - rfcr_pkg::Q_W;

  logic [CntW-1:0]            cnt_r;
  logic [RemW-1:0]            rem_r;
  logic [rfcr_pkg::Q_W-1:0]   lo_r;
  logic [rfcr_pkg::Q_W-1:0]   q_r;
  logic [rfcr_pkg::F_W-1:0]   d_r;
  logic [RemW:0]              trial;
  logic [RemW:0]              diff;
  logic                       ge;

  // shift in next numerator bit and try a subtract
  always_comb begin
    trial = {rem_r, lo_r[rfcr_pkg::Q_W-1]};
    diff  = trial - (RemW+1)'(d_r);
    ge    = (trial >= (RemW+1)'(d_r));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (start) begin
      cnt_r <= CntW'(rfcr_pkg::Q_W);
    end else if (cnt_r != '0) begin
      cnt_r <= cnt_r - CntW'(1);
    end
  end

  // upper part of numerator is already below the divisor
  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= num[rfcr_pkg::PROD_W-1:rfcr_pkg::Q_W];
      lo_r  <= num[rfcr_pkg::Q_W-1:0];
      d_r   <= den;
      q_r   <= '0;
    end else if (cnt_r != '0) begin
      rem_r <= ge ? diff[RemW-1:0] : trial[RemW-1:0];
      lo_r  <= lo_r << 1;
      q_r   <= {q_r[rfcr_pkg::Q_W-2:0], ge};
    end
  end

  assign busy = (cnt_r != '0);
  assign quo  = q_r;
endmodule
`default_nettype wire

[design/rfcr_dp.sv]
// Datapath: bracket and function registers, cubic evaluation, secant point,
// config registers and result registers. Depends on rfcr_pkg, rfcr_mul, rfcr_div.
`default_nettype none
module rfcr_dp #(
  parameter int FRAC_BITS     = rfcr_pkg::FRAC_BITS_DEF,
  parameter int MAX_ITER_BITS = rfcr_pkg::MAX_ITER_BITS_DEF
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst_n,
  input  wire rfcr_pkg::dp_cmd_t                    cmd,
  output rfcr_pkg::dp_sts_t                         sts,
  input  wire logic                                 cfg_we,
  input  wire logic [rfcr_pkg::CFG_IDX_W-1:0]       cfg_idx,
  input  wire logic [rfcr_pkg::CFG_DATA_W-1:0]      cfg_wdata,
  input  wire logic signed [rfcr_pkg::IN_W-1:0]     in_lower,
  input  wire logic signed [rfcr_pkg::IN_W-1:0]     in_upper,
  output logic signed [rfcr_pkg::IN_W-1:0]          res_root,
  output logic signed [rfcr_pkg::RES_W-1:0]         res_residual,
  output logic [rfcr_pkg::ST_W-1:0]                 res_status,
  output logic [MAX_ITER_BITS-1:0]                  res_iters
);
  localparam int IW = rfcr_pkg::IN_W;
  localparam int FW = rfcr_pkg::F_W;
  localparam logic signed [FW-1:0] Three = FW'(3) <<< FRAC_BITS;

  // config
  logic [rfcr_pkg::TOL_W-1:0]   wtol_r;
  logic [rfcr_pkg::TOL_W-1:0]   rtol_r;
  logic [MAX_ITER_BITS-1:0]     lim_r;

  // working registers
  logic signed [IW-1:0]         a_r, b_r, x_r, ev_r;
  logic signed [FW-1:0]         fa_r, fb_r, fx_r, cube_r;
  logic [MAX_ITER_BITS-1:0]     it_r;

  logic [IW-1:0]                ev_mag;
  logic [rfcr_pkg::PROD_W-1:0]  prod;
  logic [rfcr_pkg::PROD_W-1:0]  prod_sh;
  logic [rfcr_pkg::Q_W-1:0]     quo;
  logic [FW-1:0]                fa_mag, fb_mag, fx_mag;
  logic signed [IW:0]           width_ab;
  logic [IW:0]                  width_mag;
  logic signed [FW-1:0]         f_val;
  logic signed [IW+1:0]         x_calc;
  logic [rfcr_pkg::MUL_A_W-1:0] mul_a;
  logic [rfcr_pkg::MUL_B_W-1:0] mul_b;
  logic [MAX_ITER_BITS-1:0]     lim_eff;
  logic                         mul_busy, div_busy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wtol_r <= rfcr_pkg::WTOL_RST;
      rtol_r <= rfcr_pkg::RTOL_RST;
      lim_r  <= MAX_ITER_BITS'(rfcr_pkg::LIMIT_RST);
    end else if (cfg_we) begin
      if (cfg_idx == rfcr_pkg::CFG_WTOL) begin
        wtol_r <= cfg_wdata[rfcr_pkg::TOL_W-1:0];
      end else if (cfg_idx == rfcr_pkg::CFG_RTOL) begin
        rtol_r <= cfg_wdata[rfcr_pkg::TOL_W-1:0];
      end else if (cfg_idx == rfcr_pkg::CFG_LIMIT) begin
        lim_r <= cfg_wdata[MAX_ITER_BITS-1:0];
      end
    end
  end

  // magnitudes and bracket width
  always_comb begin
    ev_mag    = ev_r[IW-1] ? IW'(-ev_r) : IW'(ev_r);
    fa_mag    = fa_r[FW-1] ? FW'(-fa_r) : FW'(fa_r);
    fb_mag    = fb_r[FW-1] ? FW'(-fb_r) : FW'(fb_r);
    fx_mag    = fx_r[FW-1] ? FW'(-fx_r) : FW'(fx_r);
    width_ab  = (IW+1)'(b_r) - (IW+1)'(a_r);
    width_mag = width_ab[IW] ? (IW+1)'(-width_ab) : (IW+1)'(width_ab);
  end

  // multiplier operand select
  always_comb begin
    unique case (cmd.mul_src)
      rfcr_pkg::MS_SQ: begin
        mul_a = rfcr_pkg::MUL_A_W'(ev_mag);
        mul_b = rfcr_pkg::MUL_B_W'(ev_mag);
      end
      rfcr_pkg::MS_CUBE: begin
        mul_a = rfcr_pkg::MUL_A_W'(prod[2*IW-1:0]);
        mul_b = rfcr_pkg::MUL_B_W'(ev_mag);
      end
      default: begin
        mul_a = fa_mag;
        mul_b = rfcr_pkg::MUL_B_W'(width_mag);
      end
    endcase
  end

  rfcr_mul u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cmd.mul_start),
    .op_a  (mul_a),
    .op_b  (mul_b),
    .busy  (mul_busy),
    .prod  (prod)
  );

  rfcr_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cmd.div_start),
    .num   (prod),
    .den   (fa_mag + fb_mag),
    .busy  (div_busy),
    .quo   (quo)
  );

  // cube tail, polynomial and secant point
  always_comb begin
    prod_sh = prod >> (2 * FRAC_BITS);
    f_val   = cube_r - ((FW'(ev_r) <<< 3) + FW'(ev_r)) + Three;
    if (width_ab[IW]) begin
      x_calc = (IW+2)'(a_r) - (IW+2)'(quo);
    end else begin
      x_calc = (IW+2)'(a_r) + (IW+2)'(quo);
    end
    lim_eff = (lim_r == '0) ? MAX_ITER_BITS'(1) : lim_r;
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      a_r  <= in_lower;
      b_r  <= in_upper;
      ev_r <= in_lower;
    end else if (cmd.ev_load) begin
      unique case (cmd.ev_sel)
        rfcr_pkg::EV_A: ev_r <= a_r;
        rfcr_pkg::EV_B: ev_r <= b_r;
        default:        ev_r <= IW'(x_calc);
      endcase
    end
    if (cmd.x_cap) begin
      x_r <= IW'(x_calc);
    end
    if (cmd.cube_cap) begin
      cube_r <= ev_r[IW-1] ? -$signed(prod_sh[FW-1:0]) : $signed(prod_sh[FW-1:0]);
    end
    if (cmd.f_cap) begin
      unique case (cmd.f_dst)
        rfcr_pkg::FD_A: fa_r <= f_val;
        rfcr_pkg::FD_B: fb_r <= f_val;
        default:        fx_r <= f_val;
      endcase
    end
    // keep the half that still holds the sign change
    if (cmd.update) begin
      if (fa_r != '0 && fx_r != '0 && fa_r[FW-1] == fx_r[FW-1]) begin
        a_r  <= x_r;
        fa_r <= fx_r;
      end else begin
        b_r  <= x_r;
        fb_r <= fx_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      it_r <= '0;
    end else if (cmd.it_clr) begin
      it_r <= '0;
    end else if (cmd.it_inc) begin
      it_r <= it_r + MAX_ITER_BITS'(1);
    end
  end

  // result registers
  always_ff @(posedge clk) begin
    if (cmd.res_cap) begin
      res_status <= cmd.res_st;
      if (cmd.res_st == rfcr_pkg::ST_INVALID) begin
        res_root     <= '0;
        res_residual <= rfcr_pkg::sat_res(Three);
        res_iters    <= '0;
      end else begin
        res_root     <= x_r;
        res_residual <= rfcr_pkg::sat_res(fx_r);
        res_iters    <= it_r;
      end
    end
  end

  always_comb begin
    sts.mul_busy    = mul_busy;
    sts.div_busy    = div_busy;
    sts.bad_bracket = (fa_r == '0) || (fb_r == '0) || (fa_r[FW-1] == fb_r[FW-1]);
    sts.stop_hit    = (width_ab < $signed((IW+1)'(wtol_r))) ||
                      (fx_mag < FW'(rtol_r));
    sts.it_last     = (it_r == lim_eff);
  end
endmodule
`default_nettype wire

[design/rfcr_ctrl.sv]
// Controller: sequences evaluation, secant step, update and result handoff.
// Depends on rfcr_pkg and the assertion macro header.
`default_nettype none
`include "regula_falsi_cubic_root_top_macros.svh"
module rfcr_ctrl (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_ready,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output rfcr_pkg::dp_cmd_t      cmd,
  input  wire rfcr_pkg::dp_sts_t sts
);
  typedef enum logic [3:0] {
    S_IDLE, S_SQ_GO, S_SQ_W, S_CU_GO, S_CU_W, S_CAP, S_F,
    S_CHK, S_SEC_GO, S_SEC_W, S_DIV_GO, S_DIV_W, S_X, S_UPD, S_TEST, S_OUT
  } state_t;

  state_t              state_r, state_nxt;
  rfcr_pkg::f_dst_t    dst_r, dst_nxt;
  rfcr_pkg::status_t   st_r, st_nxt;
  logic                out_valid_r, out_valid_nxt;

  always_comb begin
    state_nxt     = state_r;
    dst_nxt       = dst_r;
    st_nxt        = st_r;
    cmd           = '0;
    cmd.mul_src   = rfcr_pkg::MS_SQ;
    cmd.ev_sel    = rfcr_pkg::EV_A;
    cmd.f_dst     = dst_r;
    cmd.res_st    = st_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          dst_nxt   = rfcr_pkg::FD_A;
          state_nxt = S_SQ_GO;
        end
      end
      S_SQ_GO: begin
        cmd.mul_start = 1'b1;
        cmd.mul_src   = rfcr_pkg::MS_SQ;
        state_nxt     = S_SQ_W;
      end
      S_SQ_W: begin
        if (!sts.mul_busy) state_nxt = S_CU_GO;
      end
      S_CU_GO: begin
        cmd.mul_start = 1'b1;
        cmd.mul_src   = rfcr_pkg::MS_CUBE;
        state_nxt     = S_CU_W;
      end
      S_CU_W: begin
        if (!sts.mul_busy) state_nxt = S_CAP;
      end
      S_CAP: begin
        cmd.cube_cap = 1'b1;
        state_nxt    = S_F;
      end
      S_F: begin
        cmd.f_cap = 1'b1;
        unique case (dst_r)
          rfcr_pkg::FD_A: begin
            cmd.ev_load = 1'b1;
            cmd.ev_sel  = rfcr_pkg::EV_B;
            dst_nxt     = rfcr_pkg::FD_B;
            state_nxt   = S_SQ_GO;
          end
          rfcr_pkg::FD_B: state_nxt = S_CHK;
          default:        state_nxt = S_UPD;
        endcase
      end
      S_CHK: begin
        if (sts.bad_bracket) begin
          st_nxt    = rfcr_pkg::ST_INVALID;
          state_nxt = S_OUT;
        end else begin
          cmd.it_clr = 1'b1;
          state_nxt  = S_SEC_GO;
        end
      end
      S_SEC_GO: begin
        cmd.mul_start = 1'b1;
        cmd.mul_src   = rfcr_pkg::MS_SEC;
        cmd.it_inc    = 1'b1;
        state_nxt     = S_SEC_W;
      end
      S_SEC_W: begin
        if (!sts.mul_busy) state_nxt = S_DIV_GO;
      end
      S_DIV_GO: begin
        cmd.div_start = 1'b1;
        state_nxt     = S_DIV_W;
      end
      S_DIV_W: begin
        if (!sts.div_busy) state_nxt = S_X;
      end
      S_X: begin
        cmd.x_cap   = 1'b1;
        cmd.ev_load = 1'b1;
        cmd.ev_sel  = rfcr_pkg::EV_X;
        dst_nxt     = rfcr_pkg::FD_X;
        state_nxt   = S_SQ_GO;
      end
      S_UPD: begin
        cmd.update = 1'b1;
        state_nxt  = S_TEST;
      end
      S_TEST: begin
        if (sts.stop_hit) begin
          st_nxt    = rfcr_pkg::ST_CONV;
          state_nxt = S_OUT;
        end else if (sts.it_last) begin
          st_nxt    = rfcr_pkg::ST_LIMIT;
          state_nxt = S_OUT;
        end else begin
          state_nxt = S_SEC_GO;
        end
      end
      S_OUT: begin
        // wait for the output register to free up
        if (!out_valid_r || out_ready) begin
          cmd.res_cap = 1'b1;
          state_nxt   = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.res_cap) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      dst_r       <= rfcr_pkg::FD_A;
      st_r        <= rfcr_pkg::ST_CONV;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      dst_r       <= dst_nxt;
      st_r        <= st_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;

  `RFCR_ASSERT_SAME(a_mul_free, cmd.mul_start, !sts.mul_busy, "multiplier restarted while busy")
  `RFCR_ASSERT_SAME(a_div_free, cmd.div_start, !sts.mul_busy && !sts.div_busy, "divider started early")
  `RFCR_ASSERT_SAME(a_res_free, cmd.res_cap, !out_valid_r || out_ready, "result overwritten")
  `RFCR_ASSERT_NEXT(a_accept_busy, in_valid && in_ready, !in_ready && !cmd.res_cap, "accept not taken up")
endmodule
`default_nettype wire

[design/regula_falsi_cubic_root_top.sv]
// Regula falsi root finder for f(x) = x^3 - 9x + 3 on a signed Q6.24 bracket.
// One item is worked at a time. f(a) and f(b) each take two passes of the
// bit-serial multiplier, and each false position iteration takes two more for
// f(x), one for the secant product and one pass of the restoring divider. The
// input is taken again while a finished result still waits in the output
// register.
// Depends on rfcr_pkg, rfcr_if, rfcr_dp and rfcr_ctrl.
`default_nettype none
module regula_falsi_cubic_root_top #(
  parameter int FRAC_BITS     = rfcr_pkg::FRAC_BITS_DEF,
  parameter int MAX_ITER_BITS = rfcr_pkg::MAX_ITER_BITS_DEF
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  rfcr_in_if.sink                              in_ch,
  rfcr_out_if.source                           out_ch,
  input  wire logic                            cfg_we,
  input  wire logic [rfcr_pkg::CFG_IDX_W-1:0]  cfg_idx,
  input  wire logic [rfcr_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  rfcr_pkg::dp_cmd_t cmd;
  rfcr_pkg::dp_sts_t sts;

  rfcr_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .cmd       (cmd),
    .sts       (sts)
  );

  rfcr_dp #(
    .FRAC_BITS     (FRAC_BITS),
    .MAX_ITER_BITS (MAX_ITER_BITS)
  ) u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd          (cmd),
    .sts          (sts),
    .cfg_we       (cfg_we),
    .cfg_idx      (cfg_idx),
    .cfg_wdata    (cfg_wdata),
    .in_lower     (in_ch.lower_bound),
    .in_upper     (in_ch.upper_bound),
    .res_root     (out_ch.root),
    .res_residual (out_ch.residual),
    .res_status   (out_ch.status),
    .res_iters    (out_ch.iterations)
  );
endmodule
`default_nettype wire

[tb/regula_falsi_cubic_root_top_tb.sv]
// Testbench for the regula falsi cubic root finder: directed brackets, then random ones.
// Results are checked against a built-in false position predictor.
// Depends on rfcr_pkg, rfcr_if and regula_falsi_cubic_root_top.
`timescale 1ns / 100ps
module regula_falsi_cubic_root_top_tb;

  localparam int IW = rfcr_pkg::IN_W;
  localparam logic [rfcr_pkg::CFG_IDX_W-1:0] CFG_SPARE = 2'd3;   // unused index, must be ignored
  localparam int STALL_LIMIT = 200000;
  localparam int HOLD_CYCLES = 8000;
  localparam logic signed [IW-1:0] Q_MIN = -(30'sd1 <<< 29);
  localparam logic signed [IW-1:0] Q_MAX = (30'sd1 <<< 29) - 30'sd1;
  localparam logic signed [IW-1:0] Q_ONE = 30'sd1 <<< 24;

  typedef struct {
    logic signed [rfcr_pkg::IN_W-1:0]  root;
    logic signed [rfcr_pkg::RES_W-1:0] residual;
    logic [rfcr_pkg::ST_W-1:0]         status;
    logic [7:0]                        iterations;
  } root_res_t;

  typedef struct {
    logic signed [rfcr_pkg::IN_W-1:0] lo;
    logic signed [rfcr_pkg::IN_W-1:0] hi;
    bit                               typed;
    root_res_t                        res;
  } bracket_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [rfcr_pkg::CFG_IDX_W-1:0] cfg_idx = '0;
  logic [rfcr_pkg::CFG_DATA_W-1:0] cfg_wdata = '0;

  rfcr_in_if  in_ch ();
  rfcr_out_if out_ch ();

  regula_falsi_cubic_root_top dut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch.sink), .out_ch(out_ch.source),
    .cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_wdata(cfg_wdata)
  );

  always #1 clk = ~clk;

  // mirror of the configuration registers
  logic [rfcr_pkg::TOL_W-1:0] width_tol;
  logic [rfcr_pkg::TOL_W-1:0] resid_tol;
  logic [7:0]                 iter_limit;

  root_res_t pending_roots[$];
  int  errors = 0;
  int  n_sent = 0;
  int  n_recv = 0;
  int  idle_cycles = 0;
  bit  no_idle = 0;
  bit  hold_req = 0;

  // magnitude of a 64-bit signed value
  function automatic logic [63:0] mag64(input logic signed [63:0] v);
    return v < 0 ? 64'(-v) : 64'(v);
  endfunction

  // f(x) = x^3 - 9x + 3, cube truncated toward zero
  function automatic logic signed [63:0] cubic_val(input logic signed [63:0] x);
    logic [127:0] m;
    logic [127:0] c;
    logic signed [63:0] cube;
    m = {64'd0, mag64(x)};
    c = (m * m * m) >> 48;
    cube = c[63:0];
    if (x < 0) cube = -cube;
    return cube - 64'sd9 * x + (64'sd3 <<< 24);
  endfunction

  function automatic logic signed [rfcr_pkg::RES_W-1:0] clamp_res(input logic signed [63:0] v);
    if (v > (64'sd1 <<< 38) - 64'sd1) v = (64'sd1 <<< 38) - 64'sd1;
    if (v < -(64'sd1 <<< 38)) v = -(64'sd1 <<< 38);
    return v[rfcr_pkg::RES_W-1:0];
  endfunction

  // false position search as the block should perform it
  function automatic root_res_t find_root(input logic signed [IW-1:0] lo_in,
                                          input logic signed [IW-1:0] hi_in);
    logic signed [63:0] a, b, fa, fb, x, fx, d;
    logic [127:0] num, den, q;
    int lim, it, done;
    bit conv;
    root_res_t r;
    a = 64'(lo_in); b = 64'(hi_in);
    fa = cubic_val(a); fb = cubic_val(b);
    x = '0; fx = '0; done = 0; conv = 0;
    lim = (iter_limit == 8'd0) ? 1 : int'(iter_limit);
    if (fa == 0 || fb == 0 || ((fa < 0) == (fb < 0))) begin
      r.root = '0;
      r.residual = clamp_res(cubic_val(64'sd0));
      r.status = rfcr_pkg::ST_INVALID;
      r.iterations = '0;
      return r;
    end
    for (it = 1; it <= lim; it++) begin
      d = b - a;
      num = {64'd0, mag64(d)} * {64'd0, mag64(fa)};
      den = {64'd0, mag64(fa)} + {64'd0, mag64(fb)};
      q = num / den;
      x = (d < 0) ? a - $signed(q[63:0]) : a + $signed(q[63:0]);
      fx = cubic_val(x);
      done = it;
      if (fa != 0 && fx != 0 && ((fa < 0) == (fx < 0))) begin
        a = x; fa = fx;
      end else begin
        b = x; fb = fx;
      end
      if ((b - a) < $signed({39'd0, width_tol}) || mag64(fx) < {39'd0, resid_tol}) begin
        conv = 1;
        break;
      end
    end
    r.root = x[IW-1:0];
    r.residual = clamp_res(fx);
    r.status = conv ? rfcr_pkg::ST_CONV : rfcr_pkg::ST_LIMIT;
    r.iterations = done[7:0];
    return r;
  endfunction

  task automatic write_reg(input logic [rfcr_pkg::CFG_IDX_W-1:0] idx,
                           input logic [rfcr_pkg::CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_we = 1'b1; cfg_idx = idx; cfg_wdata = val;
    @(negedge clk);
    cfg_we = 1'b0;
    case (idx)
      rfcr_pkg::CFG_WTOL:  width_tol = val;
      rfcr_pkg::CFG_RTOL:  resid_tol = val;
      rfcr_pkg::CFG_LIMIT: iter_limit = val[7:0];
      default: ;
    endcase
  endtask

  // wait until the block has drained, then let it settle
  task automatic drain;
    while (pending_roots.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  // offer one bracket; record the expectation at the accepting edge
  task automatic send_bracket(input bracket_row_t row);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 12);
    repeat (gap) @(negedge clk);
    in_ch.valid = 1'b1;
    in_ch.lower_bound = row.lo;
    in_ch.upper_bound = row.hi;
    forever begin
      @(posedge clk);
      if (in_ch.ready) break;
    end
    pending_roots.push_back(row.typed ? row.res : find_root(row.lo, row.hi));
    n_sent++;
    @(negedge clk);
    in_ch.valid = 1'b0;
  endtask

  function automatic logic signed [IW-1:0] pick_in(input int lo, input int hi);
    return IW'($urandom_range(hi - lo, 0) + lo);
  endfunction

  // well-formed bracket spanning one sign change, sometimes reversed, else noise
  function automatic bracket_row_t random_bracket;
    bracket_row_t row;
    int k;
    logic signed [IW-1:0] t;
    row.typed = 0;
    row.res = '{default: '0};
    k = $urandom_range(0, 2);
    case (k)
      0: begin
        row.lo = pick_in(-268435456, -53687091);
        row.hi = pick_in(-52009779, 5033164);
      end
      1: begin
        row.lo = pick_in(-52009779, 5033164);
        row.hi = pick_in(6710886, 46976204);
      end
      default: begin
        row.lo = pick_in(6710886, 46976204);
        row.hi = pick_in(47815065, 268435455);
      end
    endcase
    if ($urandom_range(0, 9) == 0) begin
      t = row.lo; row.lo = row.hi; row.hi = t;
    end
    if ($urandom_range(0, 3) == 0) begin
      row.lo = IW'($urandom);
      row.hi = IW'($urandom);
    end
    return row;
  endfunction

  function automatic bracket_row_t typed_invalid(input logic signed [IW-1:0] lo,
                                                 input logic signed [IW-1:0] hi);
    bracket_row_t row;
    row.lo = lo; row.hi = hi; row.typed = 1;
    row.res.root = '0;
    row.res.residual = rfcr_pkg::RES_W'(3) <<< 24;
    row.res.status = rfcr_pkg::ST_INVALID;
    row.res.iterations = '0;
    return row;
  endfunction

  function automatic bracket_row_t plain_row(input logic signed [IW-1:0] lo,
                                             input logic signed [IW-1:0] hi);
    bracket_row_t row;
    row.lo = lo; row.hi = hi; row.typed = 0;
    row.res = '{default: '0};
    return row;
  endfunction

  // result receiver: random ready gaps, one long hold-off on request
  initial begin
    int gap;
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        out_ch.ready = 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_req = 0;
      end
      gap = no_idle ? 0 : $urandom_range(0, 12);
      if (gap != 0) begin
        out_ch.ready = 1'b0;
        repeat (gap) @(negedge clk);
      end
      out_ch.ready = 1'b1;
      forever begin
        @(posedge clk);
        if (out_ch.valid) break;
      end
    end
  end

  // result checker
  always @(posedge clk) begin
    root_res_t e;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      n_recv++;
      if (pending_roots.size() == 0) begin
        $display("%0t: unexpected result root=%0d", $time, out_ch.root);
        errors++;
      end else begin
        e = pending_roots.pop_front();
        if (out_ch.root !== e.root) begin
          $display("%0t: root exp %0d got %0d", $time, e.root, out_ch.root);
          errors++;
        end
        if (out_ch.residual !== e.residual) begin
          $display("%0t: residual exp %0d got %0d", $time, e.residual, out_ch.residual);
          errors++;
        end
        if (out_ch.status !== e.status) begin
          $display("%0t: status exp %0d got %0d", $time, e.status, out_ch.status);
          errors++;
        end
        if (out_ch.iterations !== e.iterations) begin
          $display("%0t: iterations exp %0d got %0d", $time, e.iterations,
                   out_ch.iterations);
          errors++;
        end
      end
    end
  end

  // watchdog on cycles without any transaction
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > STALL_LIMIT) begin
      $display("%0t: no transaction for %0d cycles", $time, idle_cycles);
      $display("CHECK FAILED");
      $finish;
    end
  end

  initial begin
    bracket_row_t dir_rows[$];
    int i, p, cnt;
    in_ch.valid = 1'b0;
    in_ch.lower_bound = '0;
    in_ch.upper_bound = '0;
    width_tol = rfcr_pkg::WTOL_RST;
    resid_tol = rfcr_pkg::RTOL_RST;
    iter_limit = 8'(rfcr_pkg::LIMIT_RST);
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // directed brackets under reset settings
    dir_rows.push_back(typed_invalid(30'sd0, 30'sd0));
    dir_rows.push_back(typed_invalid(Q_ONE, IW'(2 * Q_ONE)));
    dir_rows.push_back(typed_invalid(Q_MAX, Q_MAX));
    dir_rows.push_back(typed_invalid(Q_MIN, Q_MIN));
    dir_rows.push_back(typed_invalid(Q_MIN, IW'(-4 * Q_ONE)));
    dir_rows.push_back(plain_row(Q_MIN, Q_MAX));
    dir_rows.push_back(plain_row(Q_MAX, Q_MIN));
    dir_rows.push_back(plain_row(30'sd0, Q_ONE));
    dir_rows.push_back(plain_row(Q_ONE, 30'sd0));
    dir_rows.push_back(plain_row(IW'(2 * Q_ONE), IW'(4 * Q_ONE)));
    dir_rows.push_back(plain_row(IW'(-4 * Q_ONE), IW'(-3 * Q_ONE)));
    dir_rows.push_back(plain_row(IW'(-16 * Q_ONE), IW'(16 * Q_ONE)));
    dir_rows.push_back(plain_row(30'sd1, IW'(3 * Q_ONE)));
    dir_rows.push_back(plain_row(-30'sd1, Q_ONE));
    foreach (dir_rows[i]) send_bracket(dir_rows[i]);
    drain();

    // settings sweep, extremes included, one unknown index write
    for (p = 0; p < 7; p++) begin
      case (p)
        0: begin
          write_reg(rfcr_pkg::CFG_WTOL, 25'd0); write_reg(rfcr_pkg::CFG_RTOL, 25'd0);
          write_reg(rfcr_pkg::CFG_LIMIT, 25'd255); cnt = 4;
        end
        1: begin
          write_reg(rfcr_pkg::CFG_WTOL, 25'd16777216);
          write_reg(rfcr_pkg::CFG_RTOL, 25'd16777216);
          write_reg(rfcr_pkg::CFG_LIMIT, 25'd1); cnt = 25;
        end
        2: begin
          write_reg(rfcr_pkg::CFG_LIMIT, 25'd0); write_reg(CFG_SPARE, 25'h1ffffff);
          write_reg(rfcr_pkg::CFG_WTOL, 25'd0); cnt = 15;
        end
        default: begin
          write_reg(rfcr_pkg::CFG_WTOL, 25'($urandom_range(0, 1 << 20)));
          write_reg(rfcr_pkg::CFG_RTOL, 25'($urandom_range(0, 1 << 20)));
          write_reg(rfcr_pkg::CFG_LIMIT, 25'($urandom_range(1, 12)));
          cnt = 23;
        end
      endcase
      no_idle = (p == 4);
      if (p == 5) hold_req = 1;
      for (i = 0; i < cnt; i++) send_bracket(random_bracket());
      drain();
    end

    repeat (200) @(posedge clk);
    $display("Sent %0d brackets, checked %0d results over 8 register settings,", n_sent, n_recv);
    $display("including invalid, reversed and extreme brackets and a long output stall.");
    if (errors == 0 && pending_roots.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

[filelist.f]
+incdir+design
design/rfcr_pkg.sv
design/rfcr_if.sv
design/rfcr_mul.sv
design/rfcr_div.sv
design/rfcr_dp.sv
design/rfcr_ctrl.sv
design/regula_falsi_cubic_root_top.sv
tb/regula_falsi_cubic_root_top_tb.sv
